// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file btf_checker.sv.
// Each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// File: rtl/core/btf_pkg.sv
// Shared types and constants for the background tile fetch sequencer.
// No dependencies; used by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package btf_pkg;

    // Default line width in pixels
    localparam int LINE_WIDTH_DEF = 256;

    // VRAM address map
    localparam logic [13:0] NAME_BASE = 14'h2000;
    localparam logic [13:0] ATTR_BASE = 14'h23C0;
    localparam logic [13:0] LOWER_OFS = 14'h0800;
    localparam logic [13:0] RIGHT_OFS = 14'h0400;

    // Nametable height and vertical wrap of the 2x2 layout
    localparam logic [8:0] TABLE_H = 9'd240;
    localparam logic [8:0] WRAP_Y  = 9'd480;

    // Full tile width in pixels
    localparam logic [3:0] TILE_W = 4'd8;

    // Configuration register indexes
    localparam logic CFG_SCROLL_X = 1'b0;
    localparam logic CFG_SCROLL_Y = 1'b1;

    // Output payload width (49 bits of fields padded to bytes)
    localparam int OUT_DATA_W = 56;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic emit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
        logic span_last;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/core/bg_tile_fetch_sequencer.sv
// Background tile fetch sequencer: one scanline in, 32 or 33 descriptors out.
// An accepted line moves the controller to run; each emitted span is then loaded
// into the datapath output register. Throughput: one descriptor per cycle while
// m_tready is high; the next line is accepted only after the last span of the
// current line is emitted. Reset clears scroll and walk state.
// Depends on btf_pkg, btf_ctrl and btf_datapath.
`timescale 1ns / 1ps
`default_nettype none

module bg_tile_fetch_sequencer #(
    parameter int LINE_WIDTH = btf_pkg::LINE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata: line[7:0]
    input  wire logic [7:0]                    s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata: name_addr[13:0], attr_addr[27:14], attr_shift[30:28], fine_x[33:31],
    //          fine_y[36:34], pixel_count[40:37], screen_x[48:41], zero[55:49]
    output logic [btf_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic                               m_tlast
);

    btf_pkg::cmd_t    cmd;
    btf_pkg::status_t status;

    btf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    btf_datapath #(
        .LINE_WIDTH (LINE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .line      (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

// File: rtl/core/btf_ctrl.sv
// Controller for the tile fetch sequencer: idle/run state machine.
// Depends on btf_pkg for the state, command and status types.
`timescale 1ns / 1ps
`default_nettype none

module btf_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  btf_pkg::status_t      status,
    output btf_pkg::cmd_t         cmd
);

    btf_pkg::state_t state_reg;
    btf_pkg::state_t state_next;

    // Accept a line only while idle; in run, emit a span whenever the output slot frees
    always_comb
    begin
        in_ready  = (state_reg == btf_pkg::ST_IDLE);
        cmd.start = in_valid && (state_reg == btf_pkg::ST_IDLE);
        cmd.emit  = (state_reg == btf_pkg::ST_RUN) && status.out_free;
    end

    // Next state: return to idle after the last span is emitted
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            btf_pkg::ST_IDLE:
            begin
                if (cmd.start)
                    state_next = btf_pkg::ST_RUN;
            end
            btf_pkg::ST_RUN:
            begin
                if (cmd.emit && status.span_last)
                    state_next = btf_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = btf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= btf_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// File: rtl/core/btf_datapath.sv
// Datapath for the tile fetch sequencer: scroll registers, span walker,
// address generation and output register. Depends on btf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module btf_datapath #(
    parameter int LINE_WIDTH = btf_pkg::LINE_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire logic [7:0]                    line,
    input  btf_pkg::cmd_t                      cmd,
    output btf_pkg::status_t                   status,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [btf_pkg::OUT_DATA_W-1:0]     out_data,
    output logic                               out_last
);

    localparam int POS_W = $clog2(LINE_WIDTH + 1);
    localparam int SUM_W = POS_W + 1;
    localparam int PAD_W = btf_pkg::OUT_DATA_W - 49;

    // Configuration
    logic [7:0] scroll_x_reg;
    logic [7:0] scroll_y_reg;

    // Walk state
    logic [8:0]       world_x_reg;
    logic [8:0]       world_x_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [8:0]       world_y_reg;
    logic [8:0]       world_y_next;

    // Output register
    logic        valid_reg;
    logic [13:0] name_reg;
    logic [13:0] attr_reg;
    logic [2:0]  shift_reg;
    logic [2:0]  fx_reg;
    logic [2:0]  fy_reg;
    logic [3:0]  cnt_reg;
    logic [7:0]  sx_reg;
    logic        last_reg;

    // Span values
    logic [8:0]       y_sum;
    logic [POS_W-1:0] rem;
    logic [3:0]       cnt;
    logic [2:0]       fx;
    logic [SUM_W-1:0] end_pos;
    logic             span_last;
    logic             lower;
    logic             right;
    logic [7:0]       nx;
    logic [7:0]       ny;
    logic [13:0]      table_ofs;
    logic [13:0]      name_addr;
    logic [13:0]      attr_addr;
    logic [2:0]       shift;

    // World y of the line, wrapped over the two nametable rows
    always_comb
    begin
        y_sum = {1'b0, line} + {1'b0, scroll_y_reg};
        if (y_sum >= btf_pkg::WRAP_Y)
            world_y_next = y_sum - btf_pkg::WRAP_Y;
        else
            world_y_next = y_sum;
    end

    // Span width: partial first tile, full tiles, cut at the line end
    always_comb
    begin
        rem = POS_W'(LINE_WIDTH) - pos_reg;
        if (pos_reg == '0)
        begin
            fx  = scroll_x_reg[2:0];
            cnt = btf_pkg::TILE_W - {1'b0, scroll_x_reg[2:0]};
        end
        else
        begin
            fx = 3'd0;
            if (rem < POS_W'(btf_pkg::TILE_W))
                cnt = 4'(rem);
            else
                cnt = btf_pkg::TILE_W;
        end
        end_pos   = {1'b0, pos_reg} + SUM_W'(cnt);
        span_last = (end_pos >= SUM_W'(LINE_WIDTH));
        pos_next     = pos_reg + POS_W'(cnt);
        world_x_next = world_x_reg + 9'(cnt);
    end

    // Nametable and attribute addresses for the current span
    always_comb
    begin
        lower = (world_y_reg >= btf_pkg::TABLE_H);
        right = world_x_reg[8];
        nx    = world_x_reg[7:0];
        if (lower)
            ny = 8'(world_y_reg - btf_pkg::TABLE_H);
        else
            ny = world_y_reg[7:0];
        table_ofs = (lower ? btf_pkg::LOWER_OFS : 14'd0)
                  + (right ? btf_pkg::RIGHT_OFS : 14'd0);
        name_addr = btf_pkg::NAME_BASE + table_ofs
                  + 14'({ny[7:3], 5'b00000}) + 14'(nx[7:3]);
        attr_addr = btf_pkg::ATTR_BASE + table_ofs
                  + 14'({ny[7:5], 3'b000}) + 14'(nx[7:5]);
        shift     = {ny[4], nx[4], 1'b0};
    end

    assign status.out_free  = !valid_reg || out_ready;
    assign status.span_last = span_last;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_x_reg <= 8'd0;
            scroll_y_reg <= 8'd0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == btf_pkg::CFG_SCROLL_X)
                scroll_x_reg <= cfg_data;
            if (cfg_index == btf_pkg::CFG_SCROLL_Y)
                scroll_y_reg <= cfg_data;
        end
    end

    // Load the walk on start, advance it on every emitted span
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            world_x_reg <= 9'd0;
            pos_reg     <= '0;
            world_y_reg <= 9'd0;
        end
        else if (cmd.start)
        begin
            world_x_reg <= {1'b0, scroll_x_reg};
            pos_reg     <= '0;
            world_y_reg <= world_y_next;
        end
        else if (cmd.emit)
        begin
            world_x_reg <= world_x_next;
            pos_reg     <= pos_next;
        end
    end

    // Output valid: set on emit, drop when the item is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (cmd.emit)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            name_reg  <= name_addr;
            attr_reg  <= attr_addr;
            shift_reg <= shift;
            fx_reg    <= fx;
            fy_reg    <= world_y_reg[2:0];
            cnt_reg   <= cnt;
            sx_reg    <= 8'(pos_reg);
            last_reg  <= span_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_last  = last_reg;
    assign out_data  = {{PAD_W{1'b0}}, sx_reg, cnt_reg, fy_reg, fx_reg, shift_reg,
                        attr_reg, name_reg};

endmodule

`default_nettype wire

// File: rtl/core/btf_checker.sv
// Port-level checks for the tile fetch sequencer, bound to the top level.
// Depends on assert_macros.svh and btf_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module btf_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [btf_pkg::OUT_DATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);

    logic [3:0] pixel_count;
    logic [2:0] fine_x;
    logic [2:0] attr_shift;
    logic [7:0] screen_x;

    assign attr_shift  = m_tdata[30:28];
    assign fine_x      = m_tdata[33:31];
    assign pixel_count = m_tdata[40:37];
    assign screen_x    = m_tdata[48:41];

    // A stalled item stays presented
    `ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    // A new line is not taken while one is being walked
    `ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // Span width is one to eight pixels and the quadrant shift is even
    `ASSERT_SAME(a_span_shape, m_tvalid,
        pixel_count != 4'd0 && pixel_count <= 4'd8 && !attr_shift[0])
    // Only the span at the line start can begin inside a tile
    `ASSERT_SAME(a_fine_x_first, m_tvalid && screen_x != 8'd0, fine_x == 3'd0)
    // The last span marks the line end
    `ASSERT_SAME(a_last_end, m_tvalid && m_tlast,
        (9'(screen_x) + 9'(pixel_count)) >= 9'(btf_pkg::LINE_WIDTH_DEF))

endmodule

bind bg_tile_fetch_sequencer btf_checker u_btf_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for bg_tile_fetch_sequencer: drives scanlines and scroll settings,
// predicts every span descriptor in SystemVerilog and compares it field by field.
// Depends on btf_pkg and the bg_tile_fetch_sequencer RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int LINE_W = 256;

    // One predicted span descriptor
    typedef struct {
        logic [13:0] name_addr;
        logic [13:0] attr_addr;
        logic [2:0]  attr_shift;
        logic [2:0]  fine_x;
        logic [2:0]  fine_y;
        logic [3:0]  pixel_count;
        logic [7:0]  screen_x;
        logic        is_last;
    } span_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = btf_pkg::CFG_SCROLL_X;
    logic [7:0]  cfg_data = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [btf_pkg::OUT_DATA_W-1:0] m_tdata;
    logic        m_tlast;

    // Scroll registers as the block should hold them
    logic [7:0]  cur_sx = 8'd0;
    logic [7:0]  cur_sy = 8'd0;

    span_t       span_q[$];
    int          errors = 0;
    bit          quiet = 1'b0;

    bg_tile_fetch_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop if the block hangs
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Walk one scanline and queue the descriptors the block should emit
    task automatic predict_line(input logic [7:0] ln);
        int    wy;
        int    wx;
        int    pos;
        int    fx;
        int    cnt;
        int    nx;
        int    ny;
        int    base;
        bit    fin;
        span_t s;
        wy  = (int'(ln) + int'(cur_sy)) % int'(btf_pkg::WRAP_Y);
        wx  = int'(cur_sx);
        pos = 0;
        fin = 1'b0;
        while (!fin && pos < LINE_W)
        begin
            if (pos == 0)
            begin
                fx  = int'(cur_sx) % int'(btf_pkg::TILE_W);
                cnt = int'(btf_pkg::TILE_W) - fx;
            end
            else
            begin
                fx  = 0;
                cnt = (pos + int'(btf_pkg::TILE_W) > LINE_W) ? LINE_W - pos
                                                              : int'(btf_pkg::TILE_W);
            end
            fin  = (pos + cnt >= LINE_W);
            base = 0;
            nx   = wx;
            ny   = wy;
            // Pick the nametable of the 2x2 layout
            if (wy >= int'(btf_pkg::TABLE_H))
            begin
                base += int'(btf_pkg::LOWER_OFS);
                ny = wy - int'(btf_pkg::TABLE_H);
            end
            if (wx >= 256)
            begin
                base += int'(btf_pkg::RIGHT_OFS);
                nx = wx - 256;
            end
            s.name_addr   = 14'(int'(btf_pkg::NAME_BASE) + base + (ny / 8) * 32 + nx / 8);
            s.attr_addr   = 14'(int'(btf_pkg::ATTR_BASE) + base + (ny / 32) * 8 + nx / 32);
            s.attr_shift  = 3'((((ny % 32) >= 16) ? 4 : 0) + (((nx % 32) >= 16) ? 2 : 0));
            s.fine_x      = 3'(fx);
            s.fine_y      = 3'(wy % 8);
            s.pixel_count = 4'(cnt);
            s.screen_x    = 8'(pos);
            s.is_last     = fin;
            span_q.push_back(s);
            wx  = (wx + cnt) % 512;
            pos = pos + cnt;
        end
    endtask

    // Offer one scanline, with an occasional random gap first, and hold until accepted
    task automatic send_line(input logic [7:0] ln);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(99) < 15)
            gap = $urandom_range(1, 40);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ln;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_line(ln);
    endtask

    // Stop sending and wait until every queued descriptor has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (span_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write both scroll registers on back-to-back edges; block must be idle
    task automatic set_scroll(input logic [7:0] sx, input logic [7:0] sy);
        cfg_we    <= 1'b1;
        cfg_index <= btf_pkg::CFG_SCROLL_X;
        cfg_data  <= sx;
        @(posedge clk);
        cfg_index <= btf_pkg::CFG_SCROLL_Y;
        cfg_data  <= sy;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_sx = sx;
        cur_sy = sy;
    endtask

    task automatic cmp_field(input string fname, input int unsigned want,
                             input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", fname, want, got);
            errors++;
        end
    endtask

    // Check each accepted descriptor and randomize the output ready
    always @(posedge clk)
    begin : rx_check
        span_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (span_q.size() == 0)
            begin
                $error("unexpected descriptor: m_tdata %h", m_tdata);
                errors++;
            end
            else
            begin
                want = span_q.pop_front();
                cmp_field("name_addr", want.name_addr, m_tdata[13:0]);
                cmp_field("attr_addr", want.attr_addr, m_tdata[27:14]);
                cmp_field("attr_shift", want.attr_shift, m_tdata[30:28]);
                cmp_field("fine_x", want.fine_x, m_tdata[33:31]);
                cmp_field("fine_y", want.fine_y, m_tdata[36:34]);
                cmp_field("pixel_count", want.pixel_count, m_tdata[40:37]);
                cmp_field("screen_x", want.screen_x, m_tdata[48:41]);
                cmp_field("last", want.is_last, m_tlast);
            end
        end
        m_tready <= quiet || ($urandom_range(99) >= 15);
    end

    // Reset values of the scroll registers, no write yet
    task automatic test_reset_defaults();
        send_line(8'd0);
        send_line(8'd239);
        drain();
    endtask

    // Largest scroll: right nametable crossing and deepest lower rows
    task automatic test_scroll_extremes();
        set_scroll(8'd255, 8'd239);
        send_line(8'd0);
        send_line(8'd239);
        send_line(8'd1);
        drain();
        set_scroll(8'd0, 8'd239);
        send_line(8'd1);
        send_line(8'd0);
        drain();
    endtask

    // Partial first span and the 33-span line, attribute quadrant edges
    task automatic test_fine_scroll();
        set_scroll(8'd7, 8'd0);
        send_line(8'd15);
        send_line(8'd16);
        send_line(8'd31);
        send_line(8'd32);
        drain();
        set_scroll(8'd1, 8'd0);
        send_line(8'd128);
        drain();
    endtask

    // Rows right at the switch to the lower nametable, then one row in each nametable
    task automatic test_table_crossings();
        set_scroll(8'd8, 8'd16);
        send_line(8'd223);
        send_line(8'd224);
        drain();
        set_scroll(8'd128, 8'd100);
        send_line(8'd170);
        send_line(8'd85);
        drain();
    endtask

    // Fixed then random scroll per phase, random lines, one mid-phase full drain
    task automatic test_random_lines();
        logic [7:0] sx;
        logic [7:0] sy;
        logic [7:0] ln;
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 0)
            begin
                sx = 8'd0;
                sy = 8'd0;
            end
            else if (ph == 1)
            begin
                sx = 8'd255;
                sy = 8'd239;
            end
            else
            begin
                sx = ($urandom_range(4) == 0) ? 8'd255 : 8'($urandom_range(255));
                sy = ($urandom_range(4) == 0) ? 8'd239 : 8'($urandom_range(239));
            end
            quiet = (ph == 3);
            set_scroll(sx, sy);
            for (int i = 0; i < 25; i++)
            begin
                case ($urandom_range(9))
                    0:       ln = 8'd0;
                    1:       ln = 8'd239;
                    default: ln = 8'($urandom_range(239));
                endcase
                send_line(ln);
                if (i == 12)
                    drain();
            end
            drain();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_scroll_extremes();
        test_fine_scroll();
        test_table_crossings();
        test_random_lines();
        // Let any stray descriptor show up before the verdict
        drain();
        repeat (40) @(posedge clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
